>>> sv/lpbd_pkg.sv
// Package: constants and types shared by the page buffer directory modules.
package lpbd_pkg;

  localparam int unsigned NumSlotsDef = 64;
  localparam int unsigned PageBitsDef = 16;
  localparam int unsigned FileBitsDef = 8;

  localparam int unsigned CmdW  = 3;
  localparam int unsigned FileW = 8;
  localparam int unsigned PageW = 16;
  localparam int unsigned SlotW = 6;

  typedef enum logic [CmdW-1:0] {
    CMD_GET   = 3'd0,
    CMD_MARK  = 3'd1,
    CMD_PROBE = 3'd2,
    CMD_DISC  = 3'd3,
    CMD_FLUSH = 3'd4,
    CMD_FFILE = 3'd5
  } cmd_t;

  // Action broadcast from the controller to every cell
  typedef struct packed {
    logic touch;      // hit entry to rank 0, ranks below it age
    logic fill;       // selected slot takes the new page at rank 0, others age
    logic drop;       // hit entry dropped, ranks above close up
    logic set_dirty;  // hit entry marked dirty
    logic clr_dirty;  // hit entry mark cleared
  } cell_op_t;

endpackage

>>> sv/lpbd_cell.sv
// One directory slot: tag, valid, dirty and recency rank, with match logic.
module lpbd_cell #(
  parameter int unsigned RANK_W = 6,
  parameter int unsigned FILE_BITS = 8,
  parameter int unsigned PAGE_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [FILE_BITS-1:0] key_file,
  input  logic [PAGE_BITS-1:0] key_page,
  input  lpbd_pkg::cell_op_t   op,
  input  logic                 sel,       // this cell is the hit or fill target
  input  logic [RANK_W-1:0]    ref_rank,  // rank of the hit entry
  input  logic                 clr_one,   // flush file clears this mark
  input  logic                 full,
  output logic                 match,
  output logic                 file_match,
  output logic                 valid,
  output logic                 dirty,
  output logic [RANK_W-1:0]    rank,
  output logic [FILE_BITS-1:0] tag_file,
  output logic [PAGE_BITS-1:0] tag_page
);

  assign match      = valid && tag_file == key_file && tag_page == key_page;
  assign file_match = valid && tag_file == key_file;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      dirty <= 1'b0;
      rank  <= '0;
    end else begin
      if (clr_one) dirty <= 1'b0;
      if (op.touch) begin
        if (sel) rank <= '0;
        else if (valid && rank < ref_rank) rank <= rank + 1'b1;
      end
      if (op.fill) begin
        if (sel) begin
          valid    <= 1'b1;
          dirty    <= 1'b0;
          rank     <= '0;
          tag_file <= key_file;
          tag_page <= key_page;
        end else if (valid && !full) begin
          rank <= rank + 1'b1;
        end else if (valid && full) begin
          // victim holds the top rank, so all others age without wrap
          rank <= rank + 1'b1;
        end
      end
      if (op.drop) begin
        if (sel) begin
          valid <= 1'b0;
          dirty <= 1'b0;
          rank  <= '0;
        end else if (valid && rank > ref_rank) begin
          rank <= rank - 1'b1;
        end
      end
      if (op.set_dirty && sel) dirty <= 1'b1;
      if (op.clr_dirty && sel) dirty <= 1'b0;
    end
  end

endmodule

>>> sv/lru_page_buffer_directory.sv
// Top level: LRU page buffer directory, a row of slot cells and a controller.
//
//  channel | signals                                   | handshake
//  request | command file_id page_num                  | start && !busy
//  result  | hit slot dirty load_needed write_back     | done strobe, one cycle
//          | wb_file wb_page wb_slot error last        |
//
// A request is accepted in S_IDLE, which registers the command and key;
// S_EXEC then matches, updates the cells and registers the result.
// Flush file walks the slots one a cycle and holds each find back one step
// so the final word can carry last. Reset clears valid, dirty and rank
// in every cell at once; no clearing pass.
// The receiver cannot stall results.
module lru_page_buffer_directory #(
  parameter int unsigned NUM_SLOTS = lpbd_pkg::NumSlotsDef,
  parameter int unsigned PAGE_BITS = lpbd_pkg::PageBitsDef,
  parameter int unsigned FILE_BITS = lpbd_pkg::FileBitsDef
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [lpbd_pkg::CmdW-1:0]    command,
  input  logic [lpbd_pkg::FileW-1:0]   file_id,
  input  logic [lpbd_pkg::PageW-1:0]   page_num,
  output logic                         done,
  output logic                         hit,
  output logic [lpbd_pkg::SlotW-1:0]   slot,
  output logic                         dirty,
  output logic                         load_needed,
  output logic                         write_back,
  output logic [lpbd_pkg::FileW-1:0]   wb_file,
  output logic [lpbd_pkg::PageW-1:0]   wb_page,
  output logic [lpbd_pkg::SlotW-1:0]   wb_slot,
  output logic                         error,
  output logic                         last
);

  localparam int unsigned IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_WALK, S_TAIL} state_t;

  state_t                 state;
  lpbd_pkg::cmd_t         cmd;
  logic [FILE_BITS-1:0]   kfile;
  logic [PAGE_BITS-1:0]   kpage;
  logic [IdxW-1:0]        widx;
  logic                   wfound;
  logic [IdxW-1:0]        hidx;

  logic [NUM_SLOTS-1:0]   c_match, c_fmatch, c_valid, c_dirty, c_sel, c_clr;
  logic [IdxW-1:0]        c_rank [NUM_SLOTS];
  logic [FILE_BITS-1:0]   c_file [NUM_SLOTS];
  logic [PAGE_BITS-1:0]   c_page [NUM_SLOTS];
  lpbd_pkg::cell_op_t     op;

  // Match, free slot and victim search over the row
  logic                   any_hit, any_free, full;
  logic [IdxW-1:0]        hit_idx, free_idx, vic_idx, tgt;
  always_comb begin
    any_hit  = 1'b0;
    any_free = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    vic_idx  = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (c_match[i]) begin
        any_hit = 1'b1;
        hit_idx = IdxW'(i);
      end
      if (!c_valid[i]) begin
        any_free = 1'b1;
        free_idx = IdxW'(i);
      end
      if (c_rank[i] == IdxW'(NUM_SLOTS - 1)) vic_idx = IdxW'(i);
    end
    full = !any_free;
    tgt  = any_hit ? hit_idx : (any_free ? free_idx : vic_idx);
  end

  // Cell actions for the exec cycle, and the per-slot dirty clears of the walk
  always_comb begin
    op = '0;
    if (state == S_EXEC) begin
      case (cmd)
        lpbd_pkg::CMD_GET: begin
          op.touch = any_hit;
          op.fill  = !any_hit;
        end
        lpbd_pkg::CMD_MARK:  op.set_dirty = any_hit;
        lpbd_pkg::CMD_DISC:  op.drop      = any_hit;
        lpbd_pkg::CMD_FLUSH: op.clr_dirty = any_hit;
        default: ;
      endcase
    end
    for (int i = 0; i < NUM_SLOTS; i++) begin
      c_sel[i] = tgt == IdxW'(i);
      c_clr[i] = state == S_WALK && widx == IdxW'(i) && c_fmatch[i] && c_dirty[i];
    end
  end

  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
    lpbd_cell #(.RANK_W(IdxW), .FILE_BITS(FILE_BITS), .PAGE_BITS(PAGE_BITS)) u_cell (
      .clk(clk), .rst(rst), .key_file(kfile), .key_page(kpage), .op(op),
      .sel(c_sel[g]), .ref_rank(c_rank[hit_idx]), .clr_one(c_clr[g]), .full(full),
      .match(c_match[g]), .file_match(c_fmatch[g]), .valid(c_valid[g]),
      .dirty(c_dirty[g]), .rank(c_rank[g]), .tag_file(c_file[g]), .tag_page(c_page[g])
    );
  end

  assign busy = state != S_IDLE;

  // Controller and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done        <= 1'b0;
      hit         <= 1'b0;
      slot        <= '0;
      dirty       <= 1'b0;
      load_needed <= 1'b0;
      write_back  <= 1'b0;
      wb_file     <= '0;
      wb_page     <= '0;
      wb_slot     <= '0;
      error       <= 1'b0;
      last        <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start && command <= lpbd_pkg::CmdW'(lpbd_pkg::CMD_FFILE)) begin
            cmd    <= lpbd_pkg::cmd_t'(command);
            kfile  <= FILE_BITS'(file_id);
            kpage  <= PAGE_BITS'(page_num);
            widx   <= '0;
            wfound <= 1'b0;
            state  <= (command == lpbd_pkg::CmdW'(lpbd_pkg::CMD_FFILE)) ? S_WALK : S_EXEC;
          end
        end
        S_EXEC: begin
          done  <= 1'b1;
          last  <= 1'b1;
          hit   <= any_hit;
          slot  <= any_hit ? lpbd_pkg::SlotW'(hit_idx) : '0;
          state <= S_IDLE;
          case (cmd)
            lpbd_pkg::CMD_GET: begin
              if (!any_hit) begin
                slot        <= lpbd_pkg::SlotW'(tgt);
                load_needed <= 1'b1;
                if (full && c_dirty[vic_idx]) begin
                  write_back <= 1'b1;
                  wb_file    <= lpbd_pkg::FileW'(c_file[vic_idx]);
                  wb_page    <= lpbd_pkg::PageW'(c_page[vic_idx]);
                  wb_slot    <= lpbd_pkg::SlotW'(vic_idx);
                end
              end
            end
            lpbd_pkg::CMD_PROBE: begin
              dirty <= any_hit && c_dirty[hit_idx];
              error <= !any_hit;
            end
            lpbd_pkg::CMD_FLUSH: begin
              if (any_hit) begin
                write_back <= 1'b1;
                wb_file    <= lpbd_pkg::FileW'(c_file[hit_idx]);
                wb_page    <= lpbd_pkg::PageW'(c_page[hit_idx]);
                wb_slot    <= lpbd_pkg::SlotW'(hit_idx);
              end
            end
            default: ;
          endcase
        end
        S_WALK: begin
          // one slot a cycle; the held find goes out once the next one shows up
          if (c_clr[widx]) begin
            if (wfound) begin
              done       <= 1'b1;
              hit        <= 1'b1;
              slot       <= lpbd_pkg::SlotW'(hidx);
              write_back <= 1'b1;
              wb_file    <= lpbd_pkg::FileW'(c_file[hidx]);
              wb_page    <= lpbd_pkg::PageW'(c_page[hidx]);
              wb_slot    <= lpbd_pkg::SlotW'(hidx);
            end
            wfound <= 1'b1;
            hidx   <= widx;
          end
          if (widx == IdxW'(NUM_SLOTS - 1)) begin
            state <= S_TAIL;
          end else begin
            widx <= widx + 1'b1;
          end
        end
        S_TAIL: begin
          // final word: the held find, or an empty word when none was dirty
          done  <= 1'b1;
          last  <= 1'b1;
          state <= S_IDLE;
          if (wfound) begin
            hit        <= 1'b1;
            slot       <= lpbd_pkg::SlotW'(hidx);
            write_back <= 1'b1;
            wb_file    <= lpbd_pkg::FileW'(c_file[hidx]);
            wb_page    <= lpbd_pkg::PageW'(c_page[hidx]);
            wb_slot    <= lpbd_pkg::SlotW'(hidx);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
